[rtl/odc_pkg.sv]
// Shared constants, field widths and the fixed low-pass coefficient table
// for the octave decimation cascade. No dependencies.
package odc_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int CFG_BITS     = 4;
	localparam int OCT_IDX_BITS = 3;
	localparam int OCTAVE_COUNT = 8;
	localparam int CFG_RESET    = 8;

	// Filter length and coefficient format (Q1.15)
	localparam int TAP_COUNT = 32;
	localparam int TAP_BITS  = 16;
	localparam int FRAC_BITS = 15;

	// Blackman-Harris windowed sinc, cutoff 0.225, unit DC gain
	localparam logic signed [TAP_BITS-1:0] FIR_TAPS [TAP_COUNT] = '{
		16'sd0, 16'sd1, 16'sd1, -16'sd8, -16'sd11, 16'sd38, 16'sd77, -16'sd99,
		-16'sd310, 16'sd131, 16'sd899, 16'sd111, -16'sd2156, -16'sd1374,
		16'sd5618, 16'sd13466,
		16'sd13466, 16'sd5618, -16'sd1374, -16'sd2156, 16'sd111, 16'sd899,
		16'sd131, -16'sd310, -16'sd99, 16'sd77, 16'sd38, -16'sd11, -16'sd8,
		16'sd1, 16'sd1, 16'sd0
	};

endpackage

[rtl/odc_if.sv]
// Valid/ready channels of the octave decimation cascade: sample input,
// octave result output and configuration write. Depends on odc_pkg.
interface odc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [odc_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface odc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [odc_pkg::OCT_IDX_BITS-1:0]       octave_index;
	logic signed [odc_pkg::SAMPLE_BITS-1:0] sample_out;
	logic                                   last_of_run;

	modport source (output valid, output octave_index, output sample_out,
		output last_of_run, input ready);
	modport sink   (input valid, input octave_index, input sample_out,
		input last_of_run, output ready);
endinterface

interface odc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [odc_pkg::CFG_BITS-1:0]     active_octaves;

	modport source (output valid, output active_octaves, input ready);
	modport sink   (input valid, input active_octaves, output ready);
endinterface

[rtl/octave_decimation_cascade.sv]
// Octave decimation cascade: octave 0 passes through, each higher octave is a 32-tap
// low-pass decimating by two. An accepted word is emitted as octave 0 first;
// each filtered octave adds a write, a multiply-accumulate sweep, a round and an emit.
// The single multiplier reads one tap a cycle in the sweep; a new sample is accepted only
// once the previous sample's run has ended. Reset clears control, positions, phases and
// fill flags; memory is not swept.
module octave_decimation_cascade (
	input  logic     clk,
	input  logic     arst_n,
	odc_in_if.sink   in_ch,
	odc_out_if.source out_ch,
	odc_cfg_if.sink  cfg_ch
);

	localparam int OCTAVE_COUNT = odc_pkg::OCTAVE_COUNT;
	localparam int STAGES  = OCTAVE_COUNT - 1;
	localparam int SW      = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int OW      = $clog2(OCTAVE_COUNT);
	localparam int OCW     = $clog2(OCTAVE_COUNT + 1);
	localparam int TAPS    = odc_pkg::TAP_COUNT;
	localparam int POS_W   = $clog2(TAPS);
	localparam int CNT_W   = $clog2(TAPS + 2);
	localparam int SB      = odc_pkg::SAMPLE_BITS;
	localparam int FRAC    = odc_pkg::FRAC_BITS;
	localparam int PROD_W  = odc_pkg::TAP_BITS + SB;
	localparam int ACC_W   = PROD_W + POS_W + 1;
	localparam int Q_W     = ACC_W - FRAC;
	localparam int ADDR_W  = SW + POS_W;
	localparam int DEPTH   = STAGES * TAPS;
	localparam int CFG_BITS_W = odc_pkg::CFG_BITS;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'((2 ** (SB - 1)) - 1);
	localparam logic signed [Q_W-1:0]   SAT_MIN  = -(Q_W'(2 ** (SB - 1)));

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EMIT  = 5'b00010,
		S_WRITE = 5'b00100,
		S_MAC   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	// Sequencer and per-word context
	state_t                state_q;
	logic [CFG_BITS_W-1:0] active_q;
	logic [OCW-1:0]        count_q;     // clamped number of octaves for this word
	logic [OW-1:0]         oct_q;       // octave currently being produced
	logic [SW-1:0]         stage_q;     // delay-line stage in use
	logic signed [SB-1:0]  x_q;         // sample travelling up the cascade
	logic [CNT_W-1:0]      cyc_q;       // sweep counter in S_MAC

	// Per-stage bookkeeping, read at one address at a time
	logic [POS_W-1:0]      pos_q   [STAGES];
	logic                  phase_q [STAGES];
	logic                  full_q  [STAGES];   // delay line has wrapped once

	// Delay-line memory, one row of TAPS words per stage
	logic signed [SB-1:0]  mem [DEPTH];

	// Multiply-accumulate pipeline
	logic                  issue_s1;
	logic                  ok_s1;
	logic [POS_W-1:0]      tap_s1;
	logic signed [SB-1:0]  rd_s1;
	logic                  valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// Output register
	logic                  out_valid_q;
	logic [odc_pkg::OCT_IDX_BITS-1:0] out_oct_q;
	logic signed [SB-1:0]  out_sample_q;
	logic                  out_last_q;

	// Combinational helpers
	logic                  in_take;
	logic                  out_free;
	logic                  at_top;
	logic [SW-1:0]         nxt_stage;
	logic                  emit_last;
	logic [OCW-1:0]        count_d;
	logic [POS_W-1:0]      rd_pos;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  issuing;
	logic signed [ACC_W-1:0] rnd;
	logic signed [Q_W-1:0]   qv;
	logic signed [SB-1:0]    sat;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_take      = in_ch.valid && in_ch.ready;
	assign out_free     = !out_valid_q || out_ch.ready;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.octave_index = out_oct_q;
	assign out_ch.sample_out   = out_sample_q;
	assign out_ch.last_of_run  = out_last_q;

	// Clamp the octave count: zero acts as one, beyond the build acts as the build
	always_comb begin
		if (active_q == '0) begin
			count_d = OCW'(1);
		end else if (int'(active_q) > OCTAVE_COUNT) begin
			count_d = OCW'(OCTAVE_COUNT);
		end else begin
			count_d = OCW'(active_q);
		end
	end

	// A word is the last of its run when no octave follows, or the next
	// octave only stores it and waits for its partner sample
	assign at_top    = (OCW'(oct_q) + OCW'(1)) >= count_q;
	assign nxt_stage = oct_q[SW-1:0];
	assign emit_last = at_top ? 1'b1 : !phase_q[nxt_stage];

	// Sweep from the oldest entry (current write position) to the newest
	assign rd_pos  = pos_q[stage_q] + cyc_q[POS_W-1:0];
	assign rd_addr = {stage_q, rd_pos};
	assign wr_addr = {stage_q, pos_q[stage_q]};
	assign issuing = (state_q == S_MAC) && (int'(cyc_q) < TAPS);

	// Round half up, floor by 2^FRAC, saturate
	assign rnd = acc_q + RND_HALF;
	assign qv  = rnd[ACC_W-1:FRAC];
	always_comb begin
		if (qv > SAT_MAX) begin
			sat = SB'(SAT_MAX);
		end else if (qv < SAT_MIN) begin
			sat = SB'(SAT_MIN);
		end else begin
			sat = SB'(qv);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_BITS_W'(odc_pkg::CFG_RESET);
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			active_q <= cfg_ch.active_octaves;
		end
	end

	// Sequencer and stage bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cyc_q       <= '0;
			for (int s = 0; s < STAGES; s++) begin
				pos_q[s]   <= '0;
				phase_q[s] <= 1'b0;
				full_q[s]  <= 1'b0;
			end
		end else begin
			// Drop the output word once taken, unless a new one replaces it
			if (out_valid_q && out_ch.ready && !((state_q == S_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// Hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_last && at_top) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					pos_q[stage_q] <= pos_q[stage_q] + POS_W'(1);
					if (pos_q[stage_q] == POS_W'(TAPS - 1)) begin
						full_q[stage_q] <= 1'b1;
					end
					phase_q[stage_q] <= !phase_q[stage_q];
					cyc_q <= '0;
					if (phase_q[stage_q]) begin
						state_q <= S_MAC;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MAC: begin
					// Run on past the last read so that its product reaches the accumulator before rounding
					cyc_q <= cyc_q + CNT_W'(1);
					if (cyc_q == CNT_W'(TAPS + 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_EMIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-word payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					x_q     <= in_ch.sample_in;
					oct_q   <= '0;
					count_q <= count_d;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_oct_q    <= odc_pkg::OCT_IDX_BITS'(oct_q);
					out_sample_q <= x_q;
					out_last_q   <= emit_last;
					oct_q        <= oct_q + OW'(1);
					stage_q      <= nxt_stage;
				end
			end
			S_WRITE: begin
				acc_q <= '0;
			end
			S_MAC: begin
				if (valid_s2) begin
					acc_q <= acc_q + ACC_W'(prod_s2);
				end
			end
			S_FIN: begin
				x_q <= sat;
			end
			default: begin
			end
		endcase
	end

	// Delay-line memory: write the arriving sample, read one tap a cycle.
	// The write lands before the sweep's first read, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			mem[wr_addr] <= x_q;
		end
		rd_s1 <= mem[rd_addr];
	end

	// Read qualifier and tap index are registered with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			issue_s1 <= issuing;
			valid_s2 <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		// Entries not yet written since reset read as zero
		ok_s1   <= full_q[stage_q] || (rd_pos < pos_q[stage_q]);
		tap_s1  <= cyc_q[POS_W-1:0];
		prod_s2 <= odc_pkg::FIR_TAPS[tap_s1] * (ok_s1 ? rd_s1 : SB'(0));
	end

	// An accepted word is always emitted first as octave zero
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_EMIT) && (oct_q == '0))
		else $error("accepted word did not start at octave zero");

	// A word not marked last must be followed by a filtering pass
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && out_free && !emit_last)
		|=> (state_q == S_WRITE) && phase_q[stage_q])
		else $error("run continued without a filtering pass");

	// The accumulator is final when rounding starts
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (!issue_s1 && !valid_s2))
		else $error("multiply pipeline not drained at rounding");

	// Never produce an octave beyond the clamped count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (OCW'(oct_q) < count_q))
		else $error("octave beyond active count");

endmodule

[sim/testbench.sv]
// Self-checking testbench for octave_decimation_cascade: feeds samples, predicts
// every octave word and checks the words as they leave the block.
// Depends on odc_pkg, the odc channel interfaces and the cascade top level.
`timescale 1ns / 100ps

module testbench;

	localparam int STAGES        = odc_pkg::OCTAVE_COUNT - 1;
	localparam int IDLE_PERCENT  = 37;
	localparam int SETTLE_CYCLES = 80;     // time after the last word for a store that yields no word; leave room
	localparam int HOLD_CYCLES   = 800;    // long enough to back the cascade up to its input
	localparam int REPORT_LIMIT  = 10;
	localparam int TIMEOUT_NS    = 20_000_000;

	typedef struct packed {
		logic [odc_pkg::OCT_IDX_BITS-1:0] octave;
		logic [odc_pkg::SAMPLE_BITS-1:0]  sample;
		logic                             last;
	} octave_word_t;

	logic clk;
	logic arst_n;

	odc_in_if  in_ch ();
	odc_out_if out_ch ();
	odc_cfg_if cfg_ch ();

	octave_decimation_cascade dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Samples waiting to be offered, and the octave words the cascade owes us
	logic signed [odc_pkg::SAMPLE_BITS-1:0] samples_pending [$];
	octave_word_t                           octave_words_due [$];

	// Our own copy of the filter state and the octave count register
	logic signed [odc_pkg::SAMPLE_BITS-1:0] line_mem [STAGES][odc_pkg::TAP_COUNT];
	logic [4:0]                             line_pos [STAGES];
	bit                                     line_phase [STAGES];
	logic [odc_pkg::CFG_BITS-1:0]           octaves_cfg;

	int mismatches;
	bit steady;        // no idling on either side while set
	bit hold_armed;    // request a long receiver hold-off
	int hold_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Append one sample to the queue of words still to be offered
	function automatic void enqueue_sample(input logic signed [odc_pkg::SAMPLE_BITS-1:0] s);
		samples_pending = {samples_pending, s};
	endfunction

	// Work out every octave word that one accepted sample causes, and advance
	// the filter state exactly as the cascade should.
	task automatic run_cascade(input logic signed [odc_pkg::SAMPLE_BITS-1:0] sample);
		octave_word_t                           words [$];
		octave_word_t                           w;
		logic signed [odc_pkg::SAMPLE_BITS-1:0] x;
		logic [4:0]                             pos;
		longint                                 acc;
		int                                     count;
		int                                     oct;
		int                                     k;
		bit                                     stop;

		count = int'(octaves_cfg);
		if (count < 1)
			count = 1;
		if (count > odc_pkg::OCTAVE_COUNT)
			count = odc_pkg::OCTAVE_COUNT;
		x = sample;
		w.octave = '0;
		w.sample = x;
		w.last = 1'b0;
		words = {words, w};
		stop = 1'b0;
		for (oct = 1; oct < count && !stop; oct++) begin
			pos = line_pos[oct-1];
			line_mem[oct-1][pos] = x;
			pos = pos + 5'd1;
			line_pos[oct-1] = pos;
			if (!line_phase[oct-1]) begin
				// first of a pair: store only, the cascade stops climbing here
				line_phase[oct-1] = 1'b1;
				stop = 1'b1;
			end else begin
				line_phase[oct-1] = 1'b0;
				acc = 0;
				// pos now points at the oldest sample, which meets tap 0
				for (k = 0; k < odc_pkg::TAP_COUNT; k++) begin
					acc += longint'(odc_pkg::FIR_TAPS[k]) * longint'(line_mem[oct-1][pos]);
					pos = pos + 5'd1;
				end
				// round half up, then floor by an arithmetic shift
				acc = (acc + 64'sd16384) >>> odc_pkg::FRAC_BITS;
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				x = acc[odc_pkg::SAMPLE_BITS-1:0];
				w.octave = oct[odc_pkg::OCT_IDX_BITS-1:0];
				w.sample = x;
				words = {words, w};
			end
		end
		words[words.size()-1].last = 1'b1;
		foreach (words[i])
			octave_words_due = {octave_words_due, words[i]};
	endtask

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
	endtask

	// Sample driver: predict on each accepted word, then offer the next one,
	// idling at random unless a steady stretch is on.
	always @(posedge clk or negedge arst_n) begin : sample_driver
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.sample_in <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				run_cascade(in_ch.sample_in);
			if (!in_ch.valid || in_ch.ready) begin
				if (samples_pending.size() > 0 &&
						(steady || $urandom_range(99) >= IDLE_PERCENT)) begin
					in_ch.valid <= 1'b1;
					in_ch.sample_in <= samples_pending.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted word against the oldest one due,
	// and drive ready with random stalls or a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		octave_word_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (octave_words_due.size() == 0) begin
					flag_mismatch("unexpected word: octave", -1, out_ch.octave_index);
				end else begin
					want = octave_words_due.pop_front();
					if (out_ch.octave_index !== want.octave)
						flag_mismatch("octave_index", want.octave, out_ch.octave_index);
					if (out_ch.sample_out !== want.sample)
						flag_mismatch("sample_out", $signed(want.sample), out_ch.sample_out);
					if (out_ch.last_of_run !== want.last)
						flag_mismatch("last_of_run", want.last, out_ch.last_of_run);
				end
			end
			if (hold_armed) begin
				hold_armed <= 1'b0;
				hold_left <= HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Wait for every pending sample to go in and every due word to come out,
	// then give the cascade time to finish any store that yields no word.
	task automatic settle();
		@(negedge clk);
		while (samples_pending.size() > 0 || in_ch.valid || octave_words_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the octave count; only ever called with the cascade idle
	task automatic write_octaves(input logic [odc_pkg::CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.active_octaves <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		octaves_cfg = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// Queue full-scale samples whose signs follow the taps, so that octave 1
	// fires exactly on the last one and its sum runs past the 16-bit range.
	task automatic queue_saturating_run(input bit negative);
		logic signed [odc_pkg::SAMPLE_BITS-1:0] hi;
		logic signed [odc_pkg::SAMPLE_BITS-1:0] lo;
		int                                     k;

		hi = negative ? 16'sh8000 : 16'sh7fff;
		lo = negative ? 16'sh7fff : 16'sh8000;
		// octave 1 already holds the first of a pair: add a filler to realign
		if (line_phase[0])
			enqueue_sample('0);
		for (k = 0; k < odc_pkg::TAP_COUNT; k++) begin
			if (odc_pkg::FIR_TAPS[k] > 0)
				enqueue_sample(hi);
			else if (odc_pkg::FIR_TAPS[k] < 0)
				enqueue_sample(lo);
			else
				enqueue_sample('0);
		end
	endtask

	initial begin : stimulus
		logic [odc_pkg::CFG_BITS-1:0]    cfg_plan [8];
		logic [odc_pkg::SAMPLE_BITS-1:0] r;
		int                              ph;
		int                              n;
		int                              kind;
		int                              seg_len;
		int                              i;

		cfg_plan = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd8, 4'd0, 4'd3, 4'd8};
		// drive every input to a known value from time zero
		arst_n = 1'b0;
		steady = 1'b0;
		hold_armed = 1'b0;
		mismatches = 0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.active_octaves = '0;
		octaves_cfg = odc_pkg::CFG_BITS'(odc_pkg::CFG_RESET);
		for (ph = 0; ph < STAGES; ph++) begin
			line_pos[ph] = '0;
			line_phase[ph] = 1'b0;
			for (i = 0; i < odc_pkg::TAP_COUNT; i++)
				line_mem[ph][i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes and bit patterns under the reset octave count
		enqueue_sample(16'sh0000);
		enqueue_sample(16'sh7fff);
		enqueue_sample(16'sh8000);
		enqueue_sample(16'sh0001);
		enqueue_sample(16'shffff);
		enqueue_sample(16'sh5555);
		enqueue_sample(16'shaaaa);
		enqueue_sample(16'sh7fff);
		enqueue_sample(16'sh7fff);
		enqueue_sample(16'sh8000);
		settle();

		// Zero octaves: behaves as one, only octave 0 comes out
		write_octaves(4'd0);
		enqueue_sample(16'sh1234);
		enqueue_sample(16'sh8000);
		enqueue_sample(16'sh7fff);
		settle();

		// Too many octaves: clipped to the full cascade
		write_octaves(4'd15);
		enqueue_sample(16'shedcb);
		enqueue_sample(16'sh4000);
		enqueue_sample(16'shc000);
		settle();

		// Two octaves, then back to eight: upper octaves must keep their state
		write_octaves(4'd2);
		enqueue_sample(16'sh2000);
		enqueue_sample(16'she000);
		enqueue_sample(16'sh0fff);
		settle();
		write_octaves(4'd8);
		enqueue_sample(16'sh0100);
		enqueue_sample(16'shff00);
		enqueue_sample(16'sh3333);
		settle();

		// Back-pressure: no idling, hold the receiver off while samples keep coming
		steady = 1'b1;
		for (i = 0; i < 24; i++) begin
			r = odc_pkg::SAMPLE_BITS'($urandom());
			enqueue_sample(r);
		end
		hold_armed = 1'b1;
		@(negedge clk);
		while (hold_left > 0)
			@(negedge clk);
		settle();
		steady = 1'b0;

		// Random phases: each with its own octave count, a saturating run of
		// each sign on two of them, then short segments of noise, quiet
		// signal, full-scale DC and Nyquist
		for (ph = 0; ph < 8; ph++) begin
			write_octaves(ph == 6 ? 4'($urandom_range(15)) : cfg_plan[ph]);
			if ((ph == 2 || ph == 4) && octaves_cfg >= 2)
				queue_saturating_run(ph == 2);
			n = 0;
			while (n < 4) begin
				kind = $urandom_range(5);
				seg_len = $urandom_range(2, 6);
				for (i = 0; i < seg_len; i++) begin
					case (kind)
						3: begin
							r = odc_pkg::SAMPLE_BITS'($urandom_range(511));
							r = r - 16'd256;
						end
						4: r = (i % 2 == 0) ? 16'h7fff : 16'h8000;
						5: r = (seg_len % 2 == 0) ? 16'h7fff : 16'h8000;
						default: r = odc_pkg::SAMPLE_BITS'($urandom());
					endcase
					enqueue_sample(r);
				end
				n += seg_len;
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
